// ===== hdl/mcrt_pkg.sv =====
// Types and constants shared by the multi-channel repeat timer.
// Command codes, channel states, back-end states and the queued command item.
`timescale 1ns / 1ps

package mcrt_pkg;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ALLOC  = 3'd1;
  localparam logic [2:0] MODE_START  = 3'd2;
  localparam logic [2:0] MODE_STOP   = 3'd3;
  localparam logic [2:0] MODE_DELETE = 3'd4;

  localparam logic [7:0] REPEAT_FOREVER = 8'hFF;

  localparam int MAX_CHANNELS = 16;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_ALLOC,
    CMD_START,
    CMD_STOP,
    CMD_DELETE,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    CH_FREE    = 2'd0,
    CH_STOPPED = 2'd1,
    CH_RUNNING = 2'd2
  } chan_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_REPLY
  } back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  chan;
    logic [15:0] interval;
    logic [7:0]  repeats;
    logic [15:0] tick_value;
  } cmd_t;

endpackage

// ===== hdl/mcrt_front.sv =====
// Front end: decodes an input item into a queued command.
// Depends on mcrt_pkg; out-of-range channel commands become no-ops.
`timescale 1ns / 1ps

module mcrt_front #(
  parameter int CHANNELS = 16
) (
  input  logic [2:0]    mode,
  input  logic [3:0]    channel,
  input  logic [15:0]   interval,
  input  logic [7:0]    repeats,
  input  logic [15:0]   tick_value,
  output mcrt_pkg::cmd_t cmd
);
  import mcrt_pkg::*;

  localparam int USED = (CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : CHANNELS;

  logic ch_ok;

  assign ch_ok = {1'b0, channel} < 5'(USED);

  always_comb begin
    cmd.chan       = channel;
    cmd.interval   = interval;
    cmd.repeats    = repeats;
    cmd.tick_value = tick_value;
    case (mode)
      MODE_TICK:   cmd.kind = CMD_TICK;
      MODE_ALLOC:  cmd.kind = CMD_ALLOC;
      MODE_START:  cmd.kind = ch_ok ? CMD_START : CMD_NOP;
      MODE_STOP:   cmd.kind = ch_ok ? CMD_STOP : CMD_NOP;
      MODE_DELETE: cmd.kind = ch_ok ? CMD_DELETE : CMD_NOP;
      default:     cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== hdl/mcrt_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on mcrt_pkg for the command item type.
`timescale 1ns / 1ps

module mcrt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mcrt_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output mcrt_pkg::cmd_t pop_cmd
);
  import mcrt_pkg::*;

  localparam int QD = 2;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  cmd_t          slots [QD];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(QD);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/mcrt_back.sv =====
// Back end: channel state bank and the sequencer that walks it, one channel a cycle.
// Depends on mcrt_pkg; holds the output result register.
`timescale 1ns / 1ps

module mcrt_back #(
  parameter int CHANNELS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  mcrt_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    expired_mask,
  output logic [15:0]    expire_value,
  output logic [3:0]     new_channel,
  output logic           alloc_failed
);
  import mcrt_pkg::*;

  localparam int USED = (CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : CHANNELS;
  localparam int IW   = (USED > 1) ? $clog2(USED) : 1;
  localparam logic [IW-1:0] LAST = IW'(USED - 1);

  back_state_t   state;
  back_state_t   state_next;
  cmd_t          cmd;
  logic [IW-1:0] idx;
  logic [15:0]   mask;
  logic [3:0]    grant;
  logic          failed;

  logic [15:0]   remaining       [USED];
  logic [15:0]   reload_interval [USED];
  logic [7:0]    repeat_left     [USED];
  chan_state_t   channel_state   [USED];

  logic [15:0]   rem_cur;
  logic [15:0]   rld_cur;
  logic [7:0]    rep_cur;
  chan_state_t   st_cur;
  logic [15:0]   rem_dec;

  logic          wr_en;
  logic [15:0]   rem_wr;
  logic [15:0]   rld_wr;
  logic [7:0]    rep_wr;
  chan_state_t   st_wr;
  logic          hit;
  logic          found;
  logic          walk_end;
  logic          load_out;

  assign rem_cur = remaining[idx];
  assign rld_cur = reload_interval[idx];
  assign rep_cur = repeat_left[idx];
  assign st_cur  = channel_state[idx];
  assign rem_dec = rem_cur - 16'd1;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_cmd.kind == CMD_NOP) ? BK_REPLY : BK_WALK;
        end
      end
      BK_WALK: begin
        if (walk_end) begin
          state_next = BK_REPLY;
        end
      end
      BK_REPLY: begin
        if (load_out) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    wr_en    = 1'b0;
    rem_wr   = rem_cur;
    rld_wr   = rld_cur;
    rep_wr   = rep_cur;
    st_wr    = st_cur;
    hit      = 1'b0;
    found    = 1'b0;
    walk_end = 1'b0;
    case (state)
      BK_IDLE: q_pop = q_valid;
      BK_WALK: begin
        case (cmd.kind)
          CMD_TICK: begin
            walk_end = idx == LAST;
            if (st_cur == CH_RUNNING && rem_cur != 16'd0) begin
              wr_en  = 1'b1;
              rem_wr = rem_dec;
              if (rem_dec == 16'd0) begin
                hit = 1'b1;
                if (rep_cur == REPEAT_FOREVER) begin
                  rem_wr = rld_cur;
                end else if (rep_cur != 8'd0) begin
                  rem_wr = rld_cur;
                  rep_wr = rep_cur - 8'd1;
                end
                if (rep_wr == 8'd0) begin
                  st_wr = CH_STOPPED;
                end
              end
            end
          end
          CMD_ALLOC: begin
            if (st_cur == CH_FREE) begin
              found    = 1'b1;
              walk_end = 1'b1;
              wr_en    = 1'b1;
              st_wr    = CH_STOPPED;
              rem_wr   = cmd.interval;
              rld_wr   = cmd.interval;
              rep_wr   = cmd.repeats;
            end else begin
              walk_end = idx == LAST;
            end
          end
          CMD_START: begin
            walk_end = 1'b1;
            if (st_cur != CH_FREE) begin
              wr_en  = 1'b1;
              rem_wr = rld_cur;
              st_wr  = CH_RUNNING;
            end
          end
          CMD_STOP: begin
            walk_end = 1'b1;
            if (st_cur != CH_FREE) begin
              wr_en = 1'b1;
              st_wr = CH_STOPPED;
            end
          end
          CMD_DELETE: begin
            walk_end = 1'b1;
            wr_en    = 1'b1;
            rem_wr   = 16'd0;
            rld_wr   = 16'd0;
            rep_wr   = 8'd0;
            st_wr    = CH_FREE;
          end
          default: walk_end = 1'b1;
        endcase
      end
      BK_REPLY: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd    <= q_cmd;
      mask   <= 16'd0;
      grant  <= 4'd0;
      failed <= 1'b0;
      if (q_cmd.kind == CMD_START || q_cmd.kind == CMD_STOP || q_cmd.kind == CMD_DELETE) begin
        idx <= q_cmd.chan[IW-1:0];
      end else begin
        idx <= '0;
      end
    end else if (state == BK_WALK) begin
      if (!walk_end) begin
        idx <= idx + IW'(1);
      end
      if (hit) begin
        mask <= mask | (16'd1 << idx);
      end
      if (cmd.kind == CMD_ALLOC) begin
        if (found) begin
          grant <= 4'(idx);
        end else if (walk_end) begin
          failed <= 1'b1;
        end
      end
    end
    if (load_out) begin
      expired_mask <= (cmd.kind == CMD_TICK) ? mask : 16'd0;
      expire_value <= (cmd.kind == CMD_TICK) ? cmd.tick_value : 16'd0;
      new_channel  <= grant;
      alloc_failed <= failed;
    end
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < USED; i++) begin
        remaining[i]       <= 16'd0;
        reload_interval[i] <= 16'd0;
        repeat_left[i]     <= 8'd0;
        channel_state[i]   <= CH_FREE;
      end
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        remaining[idx]       <= rem_wr;
        reload_interval[idx] <= rld_wr;
        repeat_left[idx]     <= rep_wr;
        channel_state[idx]   <= st_wr;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_WALK |-> idx <= LAST)
    else $error("walk index beyond last channel");

  a_reply_loads: assert property (@(posedge clk) disable iff (rst)
    state == BK_REPLY && load_out |=> out_valid && state == BK_IDLE)
    else $error("reply not delivered to output register");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    state == BK_WALK && (cmd.kind == CMD_START || cmd.kind == CMD_STOP ||
    cmd.kind == CMD_DELETE) |=> state == BK_REPLY)
    else $error("channel command took more than one step");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && alloc_failed |-> expired_mask == 16'd0 && new_channel == 4'd0)
    else $error("failed allocate carries other result fields");

endmodule

// ===== hdl/multi_channel_repeat_timer_core.sv =====
// Top level of the multi-channel repeat timer.
// Depends on mcrt_pkg, mcrt_front, mcrt_queue and mcrt_back.
// Commands enter through a two-item queue and are executed one at a time by a
// sequencer that visits one channel per cycle. With N = min(CHANNELS, 16), a
// tick walks all N channels, an allocate walks until it finds a free channel or
// passes the last one, and start, stop and delete visit only the named channel.
// Unused modes and commands on a channel out of range skip the walk.
// A stalled output holds the sequencer until the result is taken.
// New items are taken while the queue has room; one result is registered per item.
`timescale 1ns / 1ps

module multi_channel_repeat_timer_core #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [3:0]  channel,
  input  logic [15:0] interval,
  input  logic [7:0]  repeats,
  input  logic [15:0] tick_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] expired_mask,
  output logic [15:0] expire_value,
  output logic [3:0]  new_channel,
  output logic        alloc_failed
);
  import mcrt_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  mcrt_front #(.CHANNELS(CHANNELS)) u_front (
    .mode       (mode),
    .channel    (channel),
    .interval   (interval),
    .repeats    (repeats),
    .tick_value (tick_value),
    .cmd        (front_cmd)
  );

  mcrt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  mcrt_back #(.CHANNELS(CHANNELS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (q_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .expired_mask (expired_mask),
    .expire_value (expire_value),
    .new_channel  (new_channel),
    .alloc_failed (alloc_failed)
  );

endmodule
